>>> sv/kmp_pkg.sv
// Shared types and constants for the k-transaction max profit block.
package kmp_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 31;
  localparam int BUY_W    = 33;
  localparam int K_W      = 5;

  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};
  // Best-buy floor before any buy: -2^32
  localparam logic signed [BUY_W-1:0] BUY_FLOOR = {1'b1, {(BUY_W-1){1'b0}}};

  typedef logic [PRICE_W-1:0]         price_t;
  typedef logic [PROFIT_W-1:0]        profit_t;
  typedef logic signed [BUY_W-1:0]    buy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } kmp_state_t;

  // Slot store control
  typedef struct packed {
    logic we;   // write back the slot under update
    logic clr;  // drop all slots back to their cleared values
  } kmp_mem_ctl_t;

endpackage

>>> sv/kmp_slot_alu.sv
// Shared slot update unit: one buy/sell slot update per cycle.
module kmp_slot_alu (
  input  kmp_pkg::profit_t below,     // sell value of the slot below, this day
  input  kmp_pkg::buy_t    buy_old,
  input  kmp_pkg::profit_t sell_old,
  input  kmp_pkg::price_t  price,
  output kmp_pkg::buy_t    buy_new,
  output kmp_pkg::profit_t sell_new
);
  import kmp_pkg::*;

  logic signed [BUY_W:0]   buy_plus;
  logic signed [BUY_W:0]   below_x;
  logic signed [BUY_W-1:0] cand_buy;
  logic                    take_new;
  profit_t                 cand_sell;

  // below - p > buy  <=>  below > buy + p; a new buy then sells back at below
  assign buy_plus = {buy_old[BUY_W-1], buy_old} + $signed({{(BUY_W+1-PRICE_W){1'b0}}, price});
  assign below_x  = $signed({{(BUY_W+1-PROFIT_W){1'b0}}, below});
  assign cand_buy = $signed({{(BUY_W-PROFIT_W){1'b0}}, below})
                  - $signed({{(BUY_W-PRICE_W){1'b0}}, price});
  assign take_new = below_x > buy_plus;

  always_comb begin
    if (take_new) begin
      cand_sell = below;
    end else if (buy_plus < 0) begin
      cand_sell = '0;
    end else if (buy_plus > $signed({{(BUY_W+1-PROFIT_W){1'b0}}, PROFIT_MAX})) begin
      cand_sell = PROFIT_MAX;
    end else begin
      cand_sell = buy_plus[PROFIT_W-1:0];
    end
  end

  assign buy_new  = take_new ? cand_buy : buy_old;
  assign sell_new = (cand_sell > sell_old) ? cand_sell : sell_old;

endmodule

>>> sv/kmp_slot_store.sv
// Per-slot best-buy / best-sell memories with valid bits for fast clear.
module kmp_slot_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kmp_pkg::kmp_mem_ctl_t ctl,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  kmp_pkg::buy_t         wr_buy,
  input  kmp_pkg::profit_t      wr_sell,
  input  logic [ADDR_W-1:0]     rd_addr,
  output kmp_pkg::buy_t         rd_buy,
  output kmp_pkg::profit_t      rd_sell
);
  import kmp_pkg::*;

  buy_t             buy_mem  [DEPTH];
  profit_t          sell_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  buy_t             rd_buy_r;
  profit_t          rd_sell_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      buy_mem[wr_addr]  <= wr_buy;
      sell_mem[wr_addr] <= wr_sell;
    end
    rd_buy_r  <= buy_mem[rd_addr];
    rd_sell_r <= sell_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // untouched slots read as their cleared values
  assign rd_buy  = rd_vld_r ? rd_buy_r  : BUY_FLOOR;
  assign rd_sell = rd_vld_r ? rd_sell_r : '0;

endmodule

>>> sv/k_transaction_max_profit_core.sv
// Top level: k-transaction max profit over a streamed price series.
//
// Input stream: one word per day, in_tdata[15:0] = price, in_tlast marks the
// final day of a series. Result stream: one word per series, emitted only
// for the tlast word, out_tdata[30:0] = profit (saturated), bit 31 zero.
// cfg_we/cfg_wdata set k (max trades); k above MAX_K is treated as MAX_K.
// Write k only between series or while no word is in flight.
//
// Each day walks slots 0..k-1 through one shared update unit, one slot per
// cycle; the slot memories have a registered read, so the read of the next
// slot overlaps the update of the current one. in_tready stays low after
// acceptance through the walk and ST_FIN, so a new word waits until the day
// is done; the result word is registered in ST_FIN of the tlast word.
// Running gain sum, previous price and day count update on acceptance.
//
// On the last day the result goes into an output register; the core is ready
// for the next series while that result waits. If a second result is ready
// while the first is still stalled, the core holds until out_tready.
// Reset (rst_n low, synchronous) sets k to 2, clears the slots via their valid
// bits, zeroes gain, previous price and day count and drops out_tvalid; no clearing pass.
module k_transaction_max_profit_core #(
  parameter int MAX_K = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [kmp_pkg::K_W-1:0]   cfg_wdata,     // max_trades
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,      // [15:0] price
  input  logic                      in_tlast,      // last_day
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata      // [30:0] profit, [31] zero
);
  import kmp_pkg::*;

  localparam int SLOT_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KC_W    = $clog2(MAX_K + 1);
  localparam int DAY_SAT = 2 * MAX_K + 1;
  localparam int DAY_W   = $clog2(DAY_SAT + 1);

  kmp_state_t        state_r, state_nxt;
  logic [K_W-1:0]    cfg_r;
  price_t            price_r, price_nxt;
  logic              last_r, last_nxt;
  logic [KC_W-1:0]   k_r, k_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  profit_t           below_r, below_nxt;   // sell of the slot just updated
  price_t            prev_r, prev_nxt;
  profit_t           gain_r, gain_nxt;
  logic [DAY_W-1:0]  day_r, day_nxt;
  logic              out_valid_r, out_valid_nxt;
  profit_t           profit_r, profit_nxt;

  logic              acc;
  logic [KC_W-1:0]   k_in;
  logic [PROFIT_W:0] gain_sum;
  kmp_mem_ctl_t      mem_ctl;
  logic [SLOT_W-1:0] rd_addr;
  buy_t              rd_buy, buy_new;
  profit_t           rd_sell, sell_new;
  profit_t           result;

  assign in_tready  = (state_r == ST_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, profit_r};

  assign k_in = (int'(cfg_r) > MAX_K) ? KC_W'(MAX_K) : KC_W'(cfg_r);

  // greedy gain of this day, saturated
  assign gain_sum = {1'b0, gain_r} + (PROFIT_W+1)'(in_tdata - prev_r);

  // prime read at slot 0 on acceptance, then run one slot ahead of the update
  assign rd_addr = (state_r == ST_IDLE) ? '0 : slot_r + 1'b1;

  always_comb begin
    if (int'(day_r) < 2) begin
      result = '0;
    end else if (2 * int'(k_r) >= int'(day_r)) begin
      result = gain_r;
    end else begin
      result = below_r;   // zero when k is zero
    end
  end

  kmp_slot_store #(
    .DEPTH  (MAX_K),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_addr (slot_r),
    .wr_buy  (buy_new),
    .wr_sell (sell_new),
    .rd_addr (rd_addr),
    .rd_buy  (rd_buy),
    .rd_sell (rd_sell)
  );

  kmp_slot_alu u_alu (
    .below    (below_r),
    .buy_old  (rd_buy),
    .sell_old (rd_sell),
    .price    (price_r),
    .buy_new  (buy_new),
    .sell_new (sell_new)
  );

  always_comb begin
    state_nxt     = state_r;
    price_nxt     = price_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    below_nxt     = below_r;
    prev_nxt      = prev_r;
    gain_nxt      = gain_r;
    day_nxt       = day_r;
    profit_nxt    = profit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          price_nxt = in_tdata;
          last_nxt  = in_tlast;
          k_nxt     = k_in;
          slot_nxt  = '0;
          below_nxt = '0;
          prev_nxt  = in_tdata;
          if (day_r != '0 && in_tdata > prev_r) begin
            gain_nxt = gain_sum[PROFIT_W] ? PROFIT_MAX : gain_sum[PROFIT_W-1:0];
          end
          if (int'(day_r) < DAY_SAT) begin
            day_nxt = day_r + 1'b1;
          end
          state_nxt = (k_in == '0) ? ST_FIN : ST_WALK;
        end
      end
      ST_WALK: begin
        mem_ctl.we = 1'b1;
        below_nxt  = sell_new;
        if (int'(slot_r) == int'(k_r) - 1) begin
          state_nxt = ST_FIN;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          profit_nxt    = result;
          out_valid_nxt = 1'b1;
          mem_ctl.clr   = 1'b1;
          prev_nxt      = '0;
          gain_nxt      = '0;
          day_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= K_W'(2);
      prev_r      <= '0;
      gain_r      <= '0;
      day_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      prev_r      <= prev_nxt;
      gain_r      <= gain_nxt;
      day_r       <= day_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r  <= price_nxt;
    last_r   <= last_nxt;
    k_r      <= k_nxt;
    slot_r   <= slot_nxt;
    below_r  <= below_nxt;
    profit_r <= profit_nxt;
  end

endmodule

>>> sv/kmp_checker.sv
// Port-level checks for the k-transaction max profit core, bound to the top.
module kmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset drops the result channel
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // profit is saturated to 31 bits
  a_profit_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[31])
    else $error("profit above saturation limit");

  // every accepted word makes the sequencer busy, so in_tready drops
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready again right after acceptance");

endmodule

bind k_transaction_max_profit_core kmp_checker u_kmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
